@@ hw/rtl/yuvmab_pkg.sv @@
// ----------------------------------------------------------------------------
// yuvmab_pkg
// Shared constants and arithmetic helpers for the YUV 4:2:0 matte blender.
// ----------------------------------------------------------------------------
package yuvmab_pkg;

    // Sample and register widths
    localparam int PIX_W         = 8;
    localparam int CFG_W         = 12;
    localparam int PAIR_W        = PIX_W + 1;
    localparam int SUM_W         = 2 * PIX_W;

    // Reset / default values
    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(720);
    localparam int               MAX_WIDTH_DEF = 2048;
    localparam logic [PIX_W-1:0] FULL_SCALE    = 8'hFF;

    // (255 - a) * back + a * fore, never above 255 * 255
    function automatic logic [SUM_W-1:0] mix_sum(
        input logic [PIX_W-1:0] back,
        input logic [PIX_W-1:0] fore,
        input logic [PIX_W-1:0] a
    );
        logic [PIX_W-1:0] na;
        na = FULL_SCALE - a;
        return (SUM_W'(na) * SUM_W'(back)) + (SUM_W'(a) * SUM_W'(fore));
    endfunction

    // Exact floor(x / 255) for 0 <= x <= 255 * 255
    function automatic logic [PIX_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = (SUM_W+1)'(x) + (SUM_W+1)'(x >> PIX_W) + (SUM_W+1)'(1);
        return t[SUM_W-1:PIX_W];
    endfunction

endpackage

@@ hw/rtl/yuvmab_ram.sv @@
// ----------------------------------------------------------------------------
// yuvmab_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module yuvmab_ram #(
    parameter int DATA_W = 9,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, output holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/yuv420_matte_alpha_blend.sv @@
// ----------------------------------------------------------------------------
// yuv420_matte_alpha_blend
// Blends a foreground 4:2:0 frame over a background under an 8-bit matte.
// ----------------------------------------------------------------------------
// Usage:
//   Luma pixels enter in raster order on the s_ valid/ready channel, each with
//   its foreground/background samples, its matte and the chroma of its 2x2
//   block (chroma is only looked at on the odd row, odd column). s_frame_start
//   marks column 0 of the first (even) row. One result per pixel leaves on the
//   m_ channel: blended luma, plus blended Cb/Cr with m_chroma_valid at the
//   bottom-right pixel of each block (Cb/Cr read 0 otherwise).
//   Throughput: one pixel per clock while m_ready is high. The line store of
//   matte pair sums is written (even rows) or read (odd rows) at odd columns.
//   Pipeline: stage 1 and the store read load on accept, then the product
//   stage, then the output register.
//   When m_ready is low the pipeline holds and s_ready drops once the output
//   register and both inner stages are full; no result is dropped.
//   Reset clears position, row parity and pipeline valids, and sets
//   frame_width to 720. The line store is not cleared.
//   cfg_wr_en writes frame_width; the low bit is ignored and the width is
//   clamped to 2..MAX_WIDTH. Write only while the block is idle.
// ----------------------------------------------------------------------------
module yuv420_matte_alpha_blend
    import yuvmab_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    // pixel requests
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_frame_start,
    input  logic [PIX_W-1:0] s_back_luma,
    input  logic [PIX_W-1:0] s_fore_luma,
    input  logic [PIX_W-1:0] s_matte_luma,
    input  logic [PIX_W-1:0] s_back_cb,
    input  logic [PIX_W-1:0] s_fore_cb,
    input  logic [PIX_W-1:0] s_back_cr,
    input  logic [PIX_W-1:0] s_fore_cr,
    // results
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_out_luma,
    output logic [PIX_W-1:0] m_out_cb,
    output logic [PIX_W-1:0] m_out_cr,
    output logic             m_chroma_valid
);

    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CMP_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam logic [CMP_W-1:0] W_MIN = CMP_W'(2);
    localparam logic [CMP_W-1:0] W_MAX = CMP_W'(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Configuration and position state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic             odd_row_reg, odd_row_next;
    logic [PIX_W-1:0] left_matte_reg;

    // Pipeline valids
    logic v1_reg, v2_reg, out_v_reg;
    logic en1, en2, en3, accept;

    // Stage 1 payload
    logic [SUM_W-1:0]  luma_sum_reg;
    logic [PAIR_W-1:0] pair_reg;
    logic              chroma1_reg;
    logic [PIX_W-1:0]  bcb_reg, fcb_reg, bcr_reg, fcr_reg;

    // Stage 2 payload
    logic [PIX_W-1:0] luma_q_reg;
    logic [SUM_W-1:0] cb_sum_reg, cr_sum_reg;
    logic             chroma2_reg;

    // Output register
    logic [PIX_W-1:0] out_luma_reg, out_cb_reg, out_cr_reg;
    logic             out_chroma_reg;

    // Current pixel position and line store access
    logic [COL_W-1:0]  col_cur;
    logic              odd_cur;
    logic [PAIR_W-1:0] pair_cur;
    logic [IDX_W-1:0]  line_idx;
    logic              ram_we, ram_re;
    logic [PAIR_W-1:0] ram_rd_data;
    logic [CMP_W-1:0]  w_even, w_eff, col_inc;
    logic [PIX_W+1:0]  quad_sum;
    logic [PIX_W-1:0]  chroma_matte;

    // Handshake chain: each stage may load when the one after it frees up
    assign en3     = !out_v_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign accept  = s_valid && en1;

    // Effective width: low bit cleared, clamped to 2..MAX_WIDTH
    always_comb begin
        w_even = CMP_W'(frame_width_reg & ~CFG_W'(1));
        if (w_even < W_MIN) begin
            w_eff = W_MIN;
        end else if (w_even > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = w_even;
        end
    end

    // Position of the incoming pixel and next position
    always_comb begin
        col_cur  = s_frame_start ? '0 : col_reg;
        odd_cur  = s_frame_start ? 1'b0 : odd_row_reg;
        pair_cur = PAIR_W'(left_matte_reg) + PAIR_W'(s_matte_luma);
        line_idx = IDX_W'(col_cur >> 1);
        ram_we   = accept && col_cur[0] && !odd_cur;
        ram_re   = accept && col_cur[0] && odd_cur;
        col_inc  = CMP_W'(col_cur) + CMP_W'(1);
        if (col_inc >= w_eff) begin
            col_next     = '0;
            odd_row_next = !odd_cur;
        end else begin
            col_next     = COL_W'(col_inc);
            odd_row_next = odd_cur;
        end
    end

    // Line store of even-row matte pair sums
    yuvmab_ram #(
        .DATA_W (PAIR_W),
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_pair_line (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (line_idx),
        .wr_data (pair_cur),
        .rd_en   (ram_re),
        .rd_addr (line_idx),
        .rd_data (ram_rd_data)
    );

    // Chroma matte: average of the 2x2 block
    always_comb begin
        quad_sum     = (PIX_W+2)'(ram_rd_data) + (PIX_W+2)'(pair_reg);
        chroma_matte = PIX_W'(quad_sum >> 2);
    end

    // Control state: config, position, pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= WIDTH_RESET;
            col_reg         <= '0;
            odd_row_reg     <= 1'b0;
            left_matte_reg  <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            out_v_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                frame_width_reg <= cfg_wr_data;
            end
            if (accept) begin
                col_reg     <= col_next;
                odd_row_reg <= odd_row_next;
                if (!col_cur[0]) begin
                    left_matte_reg <= s_matte_luma;
                end
            end
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                out_v_reg <= v2_reg;
            end
        end
    end

    // Stage 1: luma products, carry pair sum and block chroma
    always_ff @(posedge aclk) begin
        if (accept) begin
            luma_sum_reg <= mix_sum(s_back_luma, s_fore_luma, s_matte_luma);
            pair_reg     <= pair_cur;
            chroma1_reg  <= col_cur[0] && odd_cur;
            bcb_reg      <= s_back_cb;
            fcb_reg      <= s_fore_cb;
            bcr_reg      <= s_back_cr;
            fcr_reg      <= s_fore_cr;
        end
    end

    // Stage 2: luma divide, chroma products from stored pair sum
    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            luma_q_reg  <= div255(luma_sum_reg);
            cb_sum_reg  <= mix_sum(bcb_reg, fcb_reg, chroma_matte);
            cr_sum_reg  <= mix_sum(bcr_reg, fcr_reg, chroma_matte);
            chroma2_reg <= chroma1_reg;
        end
    end

    // Output register: chroma divide, zero when no block completes
    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            out_luma_reg   <= luma_q_reg;
            out_cb_reg     <= chroma2_reg ? div255(cb_sum_reg) : '0;
            out_cr_reg     <= chroma2_reg ? div255(cr_sum_reg) : '0;
            out_chroma_reg <= chroma2_reg;
        end
    end

    assign m_valid        = out_v_reg;
    assign m_out_luma     = out_luma_reg;
    assign m_out_cb       = out_cb_reg;
    assign m_out_cr       = out_cr_reg;
    assign m_chroma_valid = out_chroma_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Line store is never written and read in the same cycle
    a_ram_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("line store written and read in one cycle");

    // Input only stalls when the whole pipeline is full and output is blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && v1_reg && v2_reg))
        else $error("input stalled without output backpressure");

    // Column position stays below the maximum width
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(col_reg) < W_MAX)
        else $error("column position beyond maximum width");

    // Chroma fields are zero when no block completes
    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_chroma_valid) |-> (m_out_cb == '0 && m_out_cr == '0))
        else $error("chroma output nonzero without chroma_valid");

endmodule

@@ tb/yuv420_matte_alpha_blend_tb.sv @@
// ----------------------------------------------------------------------------
// yuv420_matte_alpha_blend_tb
// Self-checking bench for the YUV 4:2:0 matte blender. Pixel requests go in
// with random gaps while the result channel is randomly stalled. A scoreboard
// tracks raster position, row parity, the matte pair line store and the width
// register, predicts every blended luma/chroma result and checks it in order.
// ----------------------------------------------------------------------------
module yuv420_matte_alpha_blend_tb
    import yuvmab_pkg::*;
();

    localparam int LINE_DEPTH   = MAX_WIDTH_DEF / 2;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = 8;    // pipeline is 3 deep, leave some slack

    typedef struct packed {
        logic             frame_start;
        logic [PIX_W-1:0] back_luma;
        logic [PIX_W-1:0] fore_luma;
        logic [PIX_W-1:0] matte_luma;
        logic [PIX_W-1:0] back_cb;
        logic [PIX_W-1:0] fore_cb;
        logic [PIX_W-1:0] back_cr;
        logic [PIX_W-1:0] fore_cr;
    } pixel_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
        logic             chroma_valid;
    } blend_out_t;

    // Expected blend results, raster position and matte pair line store
    class blend_scoreboard;
        logic [CFG_W-1:0]  frame_width;
        int                column;
        bit                odd_row;
        logic [PIX_W-1:0]  left_matte;
        logic [PAIR_W-1:0] pair_line [LINE_DEPTH];
        bit                pair_written [LINE_DEPTH];
        blend_out_t        expected_q [$];
        int                mismatches;

        function new();
            frame_width = WIDTH_RESET;
            column      = 0;
            odd_row     = 1'b0;
            left_matte  = '0;
            mismatches  = 0;
            foreach (pair_written[i]) pair_written[i] = 1'b0;
        endfunction

        // ((255 - a) * back + a * fore) / 255, truncated
        function logic [PIX_W-1:0] blend_px(int back, int fore, int a);
            int full;
            full = int'(FULL_SCALE);
            return PIX_W'(((full - a) * back + a * fore) / full);
        endfunction

        // Low bit dropped, clamped to 2..MAX_WIDTH
        function int line_width();
            int w;
            w = int'(frame_width) & 'hFFE;
            if (w < 2) w = 2;
            if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            return w;
        endfunction

        // True if the next pixel, sent without frame_start, would read a
        // line store entry that no even row has written yet
        function bit unwritten_read_next();
            return odd_row && (column % 2 == 1) &&
                   !pair_written[(column / 2) % LINE_DEPTH];
        endfunction

        // Accepted request: predict its result and advance the position
        function void note_request(pixel_req_t p);
            blend_out_t r;
            int         idx;
            int         pair;
            int         avg;
            if (p.frame_start) begin
                column  = 0;
                odd_row = 1'b0;
            end
            r.luma         = blend_px(p.back_luma, p.fore_luma, p.matte_luma);
            r.cb           = '0;
            r.cr           = '0;
            r.chroma_valid = 1'b0;
            if (column % 2 == 0) begin
                left_matte = p.matte_luma;
            end else begin
                pair = int'(left_matte) + int'(p.matte_luma);
                idx  = (column / 2) % LINE_DEPTH;
                if (!odd_row) begin
                    pair_line[idx]    = PAIR_W'(pair);
                    pair_written[idx] = 1'b1;
                end else begin
                    // block matte: average of the four samples
                    avg            = (int'(pair_line[idx]) + pair) >> 2;
                    r.cb           = blend_px(p.back_cb, p.fore_cb, avg);
                    r.cr           = blend_px(p.back_cr, p.fore_cr, avg);
                    r.chroma_valid = 1'b1;
                end
            end
            expected_q.push_back(r);
            if (column + 1 >= line_width()) begin
                column  = 0;
                odd_row = !odd_row;
            end else begin
                column = (column + 1) & 'h7FF;
            end
        endfunction

        // Accepted result: compare against the oldest prediction
        function void check_result(blend_out_t got);
            blend_out_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: luma %0d cb %0d cr %0d cv %0b",
                             got.luma, got.cb, got.cr, got.chroma_valid);
                return;
            end
            want = expected_q.pop_front();
            if (got.luma !== want.luma || got.cb !== want.cb ||
                got.cr !== want.cr || got.chroma_valid !== want.chroma_valid) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display({"mismatch: exp luma %0d cb %0d cr %0d cv %0b, ",
                              "got luma %0d cb %0d cr %0d cv %0b"},
                             want.luma, want.cb, want.cr, want.chroma_valid,
                             got.luma, got.cb, got.cr, got.chroma_valid);
            end
        endfunction
    endclass

    logic             aclk           = 1'b0;
    logic             aresetn        = 1'b0;
    logic             cfg_wr_en      = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data    = '0;
    logic             s_valid        = 1'b0;
    logic             s_ready;
    logic             s_frame_start  = 1'b0;
    logic [PIX_W-1:0] s_back_luma    = '0;
    logic [PIX_W-1:0] s_fore_luma    = '0;
    logic [PIX_W-1:0] s_matte_luma   = '0;
    logic [PIX_W-1:0] s_back_cb      = '0;
    logic [PIX_W-1:0] s_fore_cb      = '0;
    logic [PIX_W-1:0] s_back_cr      = '0;
    logic [PIX_W-1:0] s_fore_cr      = '0;
    logic             m_valid;
    logic             m_ready        = 1'b0;
    logic [PIX_W-1:0] m_out_luma;
    logic [PIX_W-1:0] m_out_cb;
    logic [PIX_W-1:0] m_out_cr;
    logic             m_chroma_valid;

    int               tx_idle_pct    = 30;
    int               rx_idle_pct    = 61;
    blend_scoreboard  store;
    blend_out_t       seen_result;

    yuv420_matte_alpha_blend dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_start  (s_frame_start),
        .s_back_luma    (s_back_luma),
        .s_fore_luma    (s_fore_luma),
        .s_matte_luma   (s_matte_luma),
        .s_back_cb      (s_back_cb),
        .s_fore_cb      (s_fore_cb),
        .s_back_cr      (s_back_cr),
        .s_fore_cr      (s_fore_cr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_luma     (m_out_luma),
        .m_out_cb       (m_out_cb),
        .m_out_cr       (m_out_cr),
        .m_chroma_valid (m_chroma_valid)
    );

    // 10 time unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: check accepted results, random back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result.luma         = m_out_luma;
            seen_result.cb           = m_out_cb;
            seen_result.cr           = m_out_cr;
            seen_result.chroma_valid = m_chroma_valid;
            store.check_result(seen_result);
        end
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Sample value biased toward the extremes
    function automatic logic [PIX_W-1:0] rand_sample();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // One pixel request: optional gap, then hold until accepted
    task automatic send_pixel(input pixel_req_t p);
        // restart the frame rather than read a store entry never written
        if (!p.frame_start && store.unwritten_read_next())
            p.frame_start = 1'b1;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid       <= 1'b1;
        s_frame_start <= p.frame_start;
        s_back_luma   <= p.back_luma;
        s_fore_luma   <= p.fore_luma;
        s_matte_luma  <= p.matte_luma;
        s_back_cb     <= p.back_cb;
        s_fore_cb     <= p.fore_cb;
        s_back_cr     <= p.back_cr;
        s_fore_cr     <= p.fore_cr;
        do @(posedge aclk); while (!s_ready);
        store.note_request(p);
    endtask

    task automatic px(input bit st, input int bl, input int fl, input int ml,
                      input int bcb, input int fcb, input int bcr, input int fcr);
        pixel_req_t p;
        p.frame_start = st;
        p.back_luma   = PIX_W'(bl);
        p.fore_luma   = PIX_W'(fl);
        p.matte_luma  = PIX_W'(ml);
        p.back_cb     = PIX_W'(bcb);
        p.fore_cb     = PIX_W'(fcb);
        p.back_cr     = PIX_W'(bcr);
        p.fore_cr     = PIX_W'(fcr);
        send_pixel(p);
    endtask

    // Width write once the pipeline has fully drained
    task automatic write_width(input logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        while (store.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en         <= 1'b0;
        store.frame_width = value;
    endtask

    // Random pixels; frame_start noise in parts per thousand
    task automatic run_phase(input int tx_pct, input int rx_pct,
                             input logic [CFG_W-1:0] width_cfg,
                             input bit first_start, input int count,
                             input int noise_pm);
        pixel_req_t p;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_width(width_cfg);
        for (int i = 0; i < count; i++) begin
            p.frame_start = (i == 0) ? first_start : ($urandom_range(999) < noise_pm);
            p.back_luma   = rand_sample();
            p.fore_luma   = rand_sample();
            p.matte_luma  = rand_sample();
            p.back_cb     = rand_sample();
            p.fore_cb     = rand_sample();
            p.back_cr     = rand_sample();
            p.fore_cr     = rand_sample();
            send_pixel(p);
        end
    endtask

    // Main sequence
    initial begin
        store = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: 4-wide frame, extremes of samples and block mattes
        write_width(12'd4);
        // even row: chroma inputs are ignored here
        px(1,   0, 255, 255, 255, 255, 255, 255);
        px(0, 255,   0, 255, 255,   0, 255,   0);
        px(0,   0, 255,   0, 255, 255, 255, 255);
        px(0, 255, 255,   0,   0,   0,   0,   0);
        // odd row: block of all-255 mattes, then block of all-zero mattes
        px(0, 128,  64, 255,   9,   9,   9,   9);
        px(0,   0, 255, 255,   0, 255, 255,   0);
        px(0,  17, 200,   0, 255, 255, 255, 255);
        px(0, 255,   0,   0, 200,  10,   0, 255);
        // even row with mid-range mattes
        px(0, 200,  17,   1, 255, 255, 255, 255);
        px(0,   1, 254, 254,   0, 255,   0, 255);
        px(0, 255,   0, 128, 255, 255, 255, 255);
        px(0,   0, 255, 127,   0,   0,   0,   0);
        // odd row, cut short by a frame start in mid-line
        px(0,  90,  90, 254, 255, 255, 255, 255);
        px(0,   3, 250,   1, 255,   0,   0, 255);
        px(1, 255, 255, 255, 255, 255,   0,   0);
        px(0,   0,   0,   0, 255, 255, 255, 255);

        // sender idles 30%, receiver 61%
        run_phase(30, 61, 12'hFFF, 1'b1, 300, 0);
        run_phase(30, 61, 12'd16,  1'b0, 150, 5);   // shrinks below position
        run_phase(30, 61, 12'd0,   1'b1,  80, 5);
        run_phase(30, 61, 12'd37,  1'b0, 200, 5);
        // sender idles 61%, receiver 30%
        run_phase(61, 30, 12'd1,    1'b0,  60, 5);
        run_phase(61, 30, 12'd2049, 1'b0,  60, 5);
        run_phase(61, 30, 12'd10,   1'b1, 200, 5);
        run_phase(61, 30, 12'd6,    1'b0, 120, 5);
        // no idling on either side
        run_phase(0, 0, 12'd720, 1'b1, 200, 5);
        run_phase(0, 0, 12'd8,   1'b0, 100, 5);
        run_phase(0, 0, 12'd2,   1'b1,  60, 5);

        // drain and report
        s_valid <= 1'b0;
        while (store.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (store.mismatches == 0 && store.expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/yuvmab_pkg.sv
hw/rtl/yuvmab_ram.sv
hw/rtl/yuv420_matte_alpha_blend.sv
tb/yuv420_matte_alpha_blend_tb.sv
